// File: src/frp_pkg.sv
// ----------------------------------------------------------------------------
// Fresnel reflectance package
// Shared widths, constants and transaction payload types for the unit.
// ----------------------------------------------------------------------------
package frp_pkg;

    localparam int VEC_W   = 16;
    localparam int IDX_W   = 16;
    localparam int REF_W   = 16;
    localparam int PROD_W  = 32;
    localparam int DOT_W   = 34;
    localparam int MAG_W   = 29;
    localparam int C_W     = 16;
    localparam int SQ_W    = 32;
    localparam int S_W     = 31;
    localparam int D_W     = 62;
    localparam int ROOT_W  = 31;
    localparam int PS_W    = 48;
    localparam int QS_W    = 47;
    localparam int PP_W    = 32;
    localparam int RS_W    = 49;
    localparam int RP_W    = 33;
    localparam int DIV_W   = 40;
    localparam int Q_W     = 21;
    localparam int QQ_W    = 41;
    localparam int SUM_W   = 42;
    localparam int SH_W    = 4;
    localparam int FRAC_SH = 26;

    localparam int LATENCY = 5 + ROOT_W + 3 + Q_W + 2;

    localparam logic signed [DOT_W-1:0] ONE_DOT     = 34'sd268435456;
    localparam logic signed [DOT_W-1:0] NEG_ONE_DOT = -34'sd268435456;
    localparam logic [IDX_W-1:0]        ONE_Q12     = 16'd4096;
    localparam logic [IDX_W-1:0]        MIN_IDX     = 16'd1;
    localparam logic [S_W-1:0]          ONE_Q30     = 31'd1073741824;
    localparam logic [SUM_W-1:0]        HALF_RND    = 42'd33554432;
    localparam logic [REF_W-1:0]        REFL_ONE    = 16'd32768;

    typedef struct packed {
        logic signed [VEC_W-1:0] incident_x;
        logic signed [VEC_W-1:0] incident_y;
        logic signed [VEC_W-1:0] incident_z;
        logic signed [VEC_W-1:0] normal_x;
        logic signed [VEC_W-1:0] normal_y;
        logic signed [VEC_W-1:0] normal_z;
        logic [IDX_W-1:0]        surface_index;
    } t_hit;

    typedef struct packed {
        logic [REF_W-1:0] reflectance;
        logic             total_reflection;
    } t_res;

endpackage

// File: src/frp_if.sv
// ----------------------------------------------------------------------------
// Fresnel reflectance channels
// Valid/ready channels for hit and result transactions.
// ----------------------------------------------------------------------------
interface frp_hit_if import frp_pkg::*; ();
    logic valid;
    logic ready;
    t_hit data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface frp_res_if import frp_pkg::*; ();
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: src/fresnel_reflectance_unit.sv
// ----------------------------------------------------------------------------
// Fresnel reflectance unit
// Unpolarised Fresnel reflectance of one ray-surface hit per transaction.
// The pipeline holds the 31-stage square root and the 21-stage dividers.
// Throughput is one transaction per cycle; a stalled output holds the whole pipe.
// Reset clears only the valid bits; no result is pending after reset.
// ----------------------------------------------------------------------------
module fresnel_reflectance_unit import frp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    frp_hit_if.sink   i_hit,
    frp_res_if.source o_res
);

    logic en;
    logic [LATENCY-1:0] r_vld;

    assign en          = !r_vld[LATENCY-1] || o_res.ready;
    assign i_hit.ready = en;
    assign o_res.valid = r_vld[LATENCY-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LATENCY-2:0], i_hit.valid};
        end
    end

    // Stage 1: component products.
    logic signed [PROD_W-1:0] r_p0, r_p1, r_p2;
    logic [IDX_W-1:0]         r_n1;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p0 <= PROD_W'(i_hit.data.incident_x) * PROD_W'(i_hit.data.normal_x);
            r_p1 <= PROD_W'(i_hit.data.incident_y) * PROD_W'(i_hit.data.normal_y);
            r_p2 <= PROD_W'(i_hit.data.incident_z) * PROD_W'(i_hit.data.normal_z);
            r_n1 <= (i_hit.data.surface_index == '0) ? MIN_IDX : i_hit.data.surface_index;
        end
    end

    // Stage 2: clamp, cosine and index selection.
    logic signed [DOT_W-1:0] n_dot, n_dcl, n_neg;
    logic [MAG_W-1:0]        n_mag;
    logic [C_W-1:0]          r_c2;
    logic [IDX_W-1:0]        r_ei2, r_et2;

    always_comb begin
        n_dot = DOT_W'(r_p0) + DOT_W'(r_p1) + DOT_W'(r_p2);
        if (n_dot > ONE_DOT) begin
            n_dcl = ONE_DOT;
        end else if (n_dot < NEG_ONE_DOT) begin
            n_dcl = NEG_ONE_DOT;
        end else begin
            n_dcl = n_dot;
        end
        n_neg = -n_dcl;
        n_mag = n_dcl[DOT_W-1] ? n_neg[MAG_W-1:0] : n_dcl[MAG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c2  <= n_mag[MAG_W-1:MAG_W-C_W];
            r_ei2 <= (n_dcl > 0) ? r_n1 : ONE_Q12;
            r_et2 <= (n_dcl > 0) ? ONE_Q12 : r_n1;
        end
    end

    // Stage 3: squares.
    logic [SQ_W-1:0]  r_cc3, r_eii3, r_ett3;
    logic [C_W-1:0]   r_c3;
    logic [IDX_W-1:0] r_ei3;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cc3  <= SQ_W'(r_c2) * SQ_W'(r_c2);
            r_eii3 <= SQ_W'(r_ei2) * SQ_W'(r_ei2);
            r_ett3 <= SQ_W'(r_et2) * SQ_W'(r_et2);
            r_c3   <= r_c2;
            r_ei3  <= r_ei2;
        end
    end

    // Stage 4: etai^2 times sin^2 of incidence.
    logic [S_W-1:0]   n_s;
    logic [D_W-1:0]   r_rhs4;
    logic [SQ_W-1:0]  r_ett4;
    logic [C_W-1:0]   r_c4;
    logic [IDX_W-1:0] r_ei4;

    assign n_s = ONE_Q30 - r_cc3[S_W-1:0];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rhs4 <= D_W'(r_eii3) * D_W'(n_s);
            r_ett4 <= r_ett3;
            r_c4   <= r_c3;
            r_ei4  <= r_ei3;
        end
    end

    // Stage 5: total internal reflection test and Rs first term.
    logic [D_W-1:0]   n_lhs;
    logic [D_W-1:0]   r_d5;
    logic             r_tir5;
    logic [PS_W-1:0]  r_ps5;
    logic [C_W-1:0]   r_c5;
    logic [IDX_W-1:0] r_ei5;

    assign n_lhs = {r_ett4, 30'd0};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d5   <= n_lhs - r_rhs4;
            r_tir5 <= r_rhs4 >= n_lhs;
            r_ps5  <= PS_W'(r_ett4) * PS_W'(r_c4);
            r_c5   <= r_c4;
            r_ei5  <= r_ei4;
        end
    end

    // Square root, one root bit per stage.
    logic [D_W-1:0]    r_sq_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_sq_root [ROOT_W];
    logic              r_sq_tir  [ROOT_W];
    logic [PS_W-1:0]   r_sq_ps   [ROOT_W];
    logic [C_W-1:0]    r_sq_c    [ROOT_W];
    logic [IDX_W-1:0]  r_sq_ei   [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
        localparam int B = ROOT_W - 1 - k;
        logic [D_W-1:0]    n_rem;
        logic [ROOT_W-1:0] n_root;
        logic              n_tir;
        logic [PS_W-1:0]   n_ps;
        logic [C_W-1:0]    n_c;
        logic [IDX_W-1:0]  n_ei;
        logic [D_W:0]      n_trial;
        logic              n_ge;

        if (k == 0) begin : g_first
            assign n_rem  = r_d5;
            assign n_root = '0;
            assign n_tir  = r_tir5;
            assign n_ps   = r_ps5;
            assign n_c    = r_c5;
            assign n_ei   = r_ei5;
        end else begin : g_next
            assign n_rem  = r_sq_rem[k-1];
            assign n_root = r_sq_root[k-1];
            assign n_tir  = r_sq_tir[k-1];
            assign n_ps   = r_sq_ps[k-1];
            assign n_c    = r_sq_c[k-1];
            assign n_ei   = r_sq_ei[k-1];
        end

        assign n_trial = ((D_W+1)'(n_root) << (B + 1)) + ((D_W+1)'(1) << (2 * B));
        assign n_ge    = {1'b0, n_rem} >= n_trial;

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_rem[k]    <= n_ge ? D_W'({1'b0, n_rem} - n_trial) : n_rem;
                r_sq_root[k]   <= n_root | (ROOT_W'(n_ge) << B);
                r_sq_tir[k]    <= n_tir;
                r_sq_ps[k]     <= n_ps;
                r_sq_c[k]      <= n_c;
                r_sq_ei[k]     <= n_ei;
            end
        end
    end

    // Product terms of both ratios.
    logic [QS_W-1:0]   r_qs6;
    logic [PS_W-1:0]   r_ps6;
    logic [PP_W-1:0]   r_pp6;
    logic [ROOT_W-1:0] r_t6;
    logic              r_tir6;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_qs6  <= QS_W'(r_sq_ei[ROOT_W-1]) * QS_W'(r_sq_root[ROOT_W-1]);
            r_pp6  <= PP_W'(r_sq_ei[ROOT_W-1]) * PP_W'(r_sq_c[ROOT_W-1]);
            r_ps6  <= r_sq_ps[ROOT_W-1];
            r_t6   <= r_sq_root[ROOT_W-1];
            r_tir6 <= r_sq_tir[ROOT_W-1];
        end
    end

    // Numerators and denominators.
    logic [RS_W-1:0] r_num_s7, r_den_s7;
    logic [RP_W-1:0] r_num_p7, r_den_p7;
    logic            r_tir7;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_den_s7 <= RS_W'(r_ps6) + RS_W'(r_qs6);
            r_num_s7 <= (r_ps6 >= PS_W'(r_qs6)) ? RS_W'(r_ps6 - PS_W'(r_qs6))
                                                : RS_W'(PS_W'(r_qs6) - r_ps6);
            r_den_p7 <= RP_W'(r_pp6) + RP_W'(r_t6);
            r_num_p7 <= (r_pp6 >= PP_W'(r_t6)) ? RP_W'(r_pp6 - PP_W'(r_t6))
                                               : RP_W'(PP_W'(r_t6) - r_pp6);
            r_tir7   <= r_tir6;
        end
    end

    // Bring the Rs denominator below 2^40.
    logic [SH_W-1:0]  n_k;
    logic [DIV_W-1:0] r_num_s8, r_den_s8, r_num_p8, r_den_p8;
    logic             r_tir8;

    always_comb begin
        n_k = '0;
        for (int b = DIV_W; b < RS_W; b++) begin
            if (r_den_s7[b]) begin
                n_k = SH_W'(b - DIV_W + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_num_s8 <= DIV_W'(r_num_s7 >> n_k);
            r_den_s8 <= DIV_W'(r_den_s7 >> n_k);
            r_num_p8 <= DIV_W'(r_num_p7);
            r_den_p8 <= DIV_W'(r_den_p7);
            r_tir8   <= r_tir7;
        end
    end

    // Ratios.
    logic [Q_W-1:0] w_rs, w_rp;
    logic           r_tir_d [Q_W];

    frp_div u_div_s (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (r_num_s8),
        .i_den  (r_den_s8),
        .o_quot (w_rs)
    );

    frp_div u_div_p (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (r_num_p8),
        .i_den  (r_den_p8),
        .o_quot (w_rp)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tir_d[0] <= r_tir8;
            for (int i = 1; i < Q_W; i++) begin
                r_tir_d[i] <= r_tir_d[i-1];
            end
        end
    end

    // Squares of the ratios.
    logic [QQ_W-1:0] r_rs2, r_rp2;
    logic            r_tir9;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rs2  <= QQ_W'(w_rs) * QQ_W'(w_rs);
            r_rp2  <= QQ_W'(w_rp) * QQ_W'(w_rp);
            r_tir9 <= r_tir_d[Q_W-1];
        end
    end

    // Mean, rounding and saturation.
    logic [SUM_W-1:0] n_sum;
    logic [REF_W-1:0] n_refl;
    t_res             r_out;

    always_comb begin
        n_sum  = SUM_W'(r_rs2) + SUM_W'(r_rp2) + HALF_RND;
        n_refl = n_sum[FRAC_SH+REF_W-1:FRAC_SH];
        if (n_refl > REFL_ONE) begin
            n_refl = REFL_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.reflectance      <= r_tir9 ? REFL_ONE : n_refl;
            r_out.total_reflection <= r_tir9;
        end
    end

    assign o_res.data = r_out;

endmodule

// File: src/frp_div.sv
// ----------------------------------------------------------------------------
// Fresnel reflectance divider
// Pipelined restoring divider giving floor(num * 2^20 / den) for num <= den,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
module frp_div import frp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [DIV_W-1:0] i_num,
    input  logic [DIV_W-1:0] i_den,
    output logic [Q_W-1:0]   o_quot
);

    logic [DIV_W-1:0] r_rem  [Q_W];
    logic [DIV_W-1:0] r_den  [Q_W];
    logic [Q_W-1:0]   r_quot [Q_W];

    for (genvar j = 0; j < Q_W; j++) begin : g_stage
        logic [DIV_W:0]   n_try;
        logic [DIV_W-1:0] n_den;
        logic [Q_W-1:0]   n_quot;
        logic             n_ge;

        if (j == 0) begin : g_first
            assign n_try  = {1'b0, i_num};
            assign n_den  = i_den;
            assign n_quot = '0;
        end else begin : g_next
            assign n_try  = {r_rem[j-1], 1'b0};
            assign n_den  = r_den[j-1];
            assign n_quot = r_quot[j-1];
        end

        assign n_ge = n_try >= {1'b0, n_den};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= n_ge ? DIV_W'(n_try - {1'b0, n_den}) : n_try[DIV_W-1:0];
                r_den[j]  <= n_den;
                r_quot[j] <= n_quot | (Q_W'(n_ge) << (Q_W - 1 - j));
            end
        end
    end

    assign o_quot = r_quot[Q_W-1];

endmodule

// File: src/frp_checker.sv
// ----------------------------------------------------------------------------
// Fresnel reflectance checker
// Port-level checks on the unit, attached to the top level by bind.
// ----------------------------------------------------------------------------
module frp_checker import frp_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input t_res i_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("Stalled result transaction changed.");

    a_tir_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.total_reflection |-> i_out_data.reflectance == REFL_ONE)
        else $error("Total reflection without full reflectance.");

    a_refl_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_data.reflectance <= REFL_ONE)
        else $error("Reflectance above one.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Result valid straight after reset.");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("Input not ready while output is empty.");

endmodule

bind fresnel_reflectance_unit frp_checker u_frp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_hit.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.data)
);

// File: verif/fresnel_reflectance_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fresnel reflectance unit testbench
// Drives hit transactions through the unit under input idling and output stall
// phases and checks every result against an independent fixed-point predictor.
// ----------------------------------------------------------------------------
module fresnel_reflectance_unit_tb;
    import frp_pkg::*;

    class reflectance_scoreboard;
        t_res pending[$];
        int   errors;

        function logic [63:0] int_sqrt(logic [63:0] d);
            logic [63:0] root;
            logic [63:0] bitv;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > d) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (d >= root + bitv) begin
                    d = d - (root + bitv);
                    root = (root >> 1) + bitv;
                end else begin
                    root = root >> 1;
                end
                bitv = bitv >> 2;
            end
            return root;
        endfunction

        function logic [63:0] fraction_q20(logic [63:0] p, logic [63:0] q);
            logic [63:0] num;
            logic [63:0] den;
            num = (p >= q) ? p - q : q - p;
            den = p + q;
            while (den >= (64'd1 << 40)) begin
                num = num >> 1;
                den = den >> 1;
            end
            if (den == 0) return 0;
            return (num << 20) / den;
        endfunction

        function t_res fresnel(t_hit h);
            t_res r;
            longint dot;
            logic [63:0] n, eta_i, eta_t, c, s, lhs, rhs, t, rs, rp, total;
            dot = longint'(h.incident_x) * longint'(h.normal_x)
                + longint'(h.incident_y) * longint'(h.normal_y)
                + longint'(h.incident_z) * longint'(h.normal_z);
            if (dot > (64'sd1 << 28)) dot = 64'sd1 << 28;
            if (dot < -(64'sd1 << 28)) dot = -(64'sd1 << 28);
            n = (h.surface_index == 0) ? 64'd1 : 64'(h.surface_index);
            if (dot > 0) begin
                eta_i = n;
                eta_t = 64'd4096;
            end else begin
                eta_i = 64'd4096;
                eta_t = n;
            end
            c = 64'(dot < 0 ? -dot : dot) >> 13;
            s = (64'd1 << 30) - c * c;
            lhs = (eta_t * eta_t) << 30;
            rhs = eta_i * eta_i * s;
            if (rhs >= lhs) begin
                r.reflectance = REFL_ONE;
                r.total_reflection = 1'b1;
                return r;
            end
            t = int_sqrt(lhs - rhs);
            rs = fraction_q20(eta_t * eta_t * c, eta_i * t);
            rp = fraction_q20(eta_i * c, t);
            total = (rs * rs + rp * rp + (64'd1 << 25)) >> 26;
            if (total > 64'd32768) total = 64'd32768;
            r.reflectance = total[15:0];
            r.total_reflection = 1'b0;
            return r;
        endfunction

        function void note_hit(t_hit h);
            pending.push_back(fresnel(h));
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result refl=%0d tir=%0b", $time,
                         got.reflectance, got.total_reflection);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.reflectance !== want.reflectance) begin
                $display("%0t: reflectance expected %0d actual %0d", $time,
                         want.reflectance, got.reflectance);
                errors++;
            end
            if (got.total_reflection !== want.total_reflection) begin
                $display("%0t: total_reflection expected %0b actual %0b", $time,
                         want.total_reflection, got.total_reflection);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    frp_hit_if hit_ch ();
    frp_res_if res_ch ();

    fresnel_reflectance_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hit   (hit_ch.sink),
        .o_res   (res_ch.source)
    );

    reflectance_scoreboard board;
    int  send_idle_pct;
    int  stall_pct;
    int  hold_off_cycles;
    longint cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > 2000000) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) board.check_result(res_ch.data);
        if (i_rst_n && hit_ch.valid && hit_ch.ready) board.note_hit(hit_ch.data);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function logic signed [15:0] rand_comp();
        case ($urandom_range(7))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'sd0;
            3: return 16'($urandom);
            default: return 16'($signed(17'($urandom_range(32768)) - 17'd16384));
        endcase
    endfunction

    function t_hit unit_hit();
        t_hit h;
        int ax;
        h.incident_x = rand_comp();
        h.incident_y = rand_comp();
        h.incident_z = rand_comp();
        h.normal_x = rand_comp();
        h.normal_y = rand_comp();
        h.normal_z = rand_comp();
        if ($urandom_range(3) != 0) begin
            ax = $urandom_range(16384);
            h.incident_x = 16'(ax);
            h.incident_y = 16'($signed(-int'($urandom_range(16384 - ax))));
            h.incident_z = 0;
            h.normal_x = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
            h.normal_y = 0;
            h.normal_z = 0;
        end
        case ($urandom_range(4))
            0: h.surface_index = 16'($urandom);
            1: h.surface_index = 16'($urandom_range(1, 8192));
            default: h.surface_index = 16'($urandom_range(4096, 7000));
        endcase
        return h;
    endfunction

    task automatic send_hit(t_hit h);
        while ($urandom_range(99) < send_idle_pct) begin
            hit_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        hit_ch.valid <= 1'b1;
        hit_ch.data <= h;
        @(posedge i_clk);
        while (!hit_ch.ready) @(posedge i_clk);
    endtask

    task automatic drain();
        hit_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    function t_hit make_hit(int ix, int iy, int iz, int nx, int ny, int nz, int idx);
        t_hit h;
        h.incident_x = 16'(ix);
        h.incident_y = 16'(iy);
        h.incident_z = 16'(iz);
        h.normal_x = 16'(nx);
        h.normal_y = 16'(ny);
        h.normal_z = 16'(nz);
        h.surface_index = 16'(idx);
        return h;
    endfunction

    initial begin
        board = new();
        send_idle_pct = 0;
        stall_pct = 0;
        hold_off_cycles = 0;
        i_rst_n = 1'b0;
        hit_ch.valid = 1'b0;
        hit_ch.data = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_hit(make_hit(-16384, 0, 0, 16384, 0, 0, 6144));
        send_hit(make_hit(16384, 0, 0, 16384, 0, 0, 6144));
        send_hit(make_hit(-32768, -32768, -32768, 32767, 32767, 32767, 4096));
        send_hit(make_hit(32767, 32767, 32767, 32767, 32767, 32767, 65535));
        send_hit(make_hit(-16384, 0, 0, 16384, 0, 0, 0));
        send_hit(make_hit(16384, 0, 0, 16384, 0, 0, 0));
        send_hit(make_hit(1, 0, 0, 1, 0, 0, 6144));
        send_hit(make_hit(-1, 0, 0, 1, 0, 0, 6144));
        send_hit(make_hit(16000, 3000, 0, 1000, 0, 0, 6144));
        send_hit(make_hit(0, 16384, 0, 16384, 0, 0, 6144));
        send_hit(make_hit(-11585, 11585, 0, 16384, 0, 0, 4096));
        send_hit(make_hit(-11585, 11585, 0, 16384, 0, 0, 1));
        send_hit(make_hit(-11585, 11585, 0, 16384, 0, 0, 65535));
        send_hit(make_hit(-5000, 15600, 0, 16384, 0, 0, 65535));
        send_hit(make_hit(0, 0, -16384, 0, 0, 16384, 32768));
        send_hit(make_hit(-21846, 21845, 21845, 21845, -21846, -21846, 43690));
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 73; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 73; end
                default: begin send_idle_pct = 34; stall_pct = 34; end
            endcase
            if (phase == 0) hold_off_cycles = 300;
            for (int k = 0; k < 320; k++) begin
                if (phase == 3 && k == 150) begin
                    stall_pct = 0;
                    send_idle_pct = 0;
                end
                send_hit(unit_hit());
            end
            drain();
        end

        repeat (LATENCY + 20) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
